// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the register block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tipr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipr_pkg
// Types and constants shared by the interprocessor register block.
// ----------------------------------------------------------------------------
package tipr_pkg;

    typedef enum logic [2:0] {
        CMD_HOST_RD = 3'd0,
        CMD_HOST_WR = 3'd1,
        CMD_PAR_RD  = 3'd2,
        CMD_PAR_WR  = 3'd3,
        CMD_RESET   = 3'd4
    } t_cmd;

    localparam logic [2:0] REG_STAT1 = 3'd0;
    localparam logic [2:0] REG_DATA1 = 3'd1;
    localparam logic [2:0] REG_STAT2 = 3'd2;
    localparam logic [2:0] REG_DATA2 = 3'd3;
    localparam logic [2:0] REG_STAT3 = 3'd4;
    localparam logic [2:0] REG_DATA3 = 3'd5;
    localparam logic [2:0] REG_STAT4 = 3'd6;
    localparam logic [2:0] REG_DATA4 = 3'd7;

    localparam int FLAG_IRQ = 0;
    localparam int FLAG_NMI = 1;
    localparam int FLAG_RST = 2;

    localparam int   PADDR_W        = 3;
    localparam logic REG_ENABLE_IDX = 1'b0;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] reg_addr;
        logic [7:0] wdata;
    } t_item;

    typedef struct packed {
        logic       rst;
        logic       nmi;
        logic       irq;
        logic [7:0] rdata;
    } t_result;

    typedef struct packed {
        logic            enable;
        logic [2:0]      flags;
        logic [1:0]      th3;
        logic [1:0]      tp3;
        logic [3:0][7:0] hs;
        logic [3:0][7:0] ps;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        enable: 1'b1,
        flags:  3'b000,
        th3:    2'd1,
        tp3:    2'd0,
        hs:     {8'h7F, 8'hFF, 8'h7F, 8'h4E},
        ps:     {8'h7F, 8'h7F, 8'h7F, 8'h40}
    };

    function automatic logic nmi_cond(input t_ctl c);
        logic lim;
        lim = c.hs[0][4];
        return c.hs[0][3] && ((c.tp3 > {1'b0, lim}) || (c.th3 == 2'd0));
    endfunction

endpackage

// File: sv/tipr_fifo_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipr_fifo_mem
// Channel 1 byte store with registered read data and write forwarding.
// ----------------------------------------------------------------------------
module tipr_fifo_mem #(
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_q
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_q <= i_wdata;
        end else begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_q = r_q;

endmodule

// File: sv/tipr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipr_out_buf
// Two-entry result queue between the access logic and the output stream.
// ----------------------------------------------------------------------------
module tipr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tipr_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output tipr_pkg::t_result o_data
);

    tipr_pkg::t_result r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_ready = (r_cnt != 2'd2);
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: sv/tipr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tipr_core
// Status, control and latch state of the four channels, updated per access.
// ----------------------------------------------------------------------------
module tipr_core #(
    parameter int DEPTH = 24,
    parameter int PW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  tipr_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_enable,
    output logic              o_enable,
    output tipr_pkg::t_result o_result,
    output logic              o_mem_we,
    output logic [PW-1:0]     o_mem_waddr,
    output logic [7:0]        o_mem_wdata,
    output logic [PW-1:0]     o_mem_raddr,
    input  logic [7:0]        i_mem_q
);

    localparam int CW = $clog2(DEPTH + 1);

    tipr_pkg::t_ctl  r_ctl, n_ctl;
    logic [3:0][7:0] r_ra, n_ra;
    logic [4:0][7:0] r_pl, n_pl;
    logic [7:0]      r_c3s, n_c3s;
    logic [PW-1:0]   r_rp, n_rp;
    logic [PW-1:0]   r_wp, n_wp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [7:0]      rdata;
    logic            nmi_pre, after;
    logic [1:0]      idx;
    logic [2:0]      a;
    logic [7:0]      v;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign a   = i_item.reg_addr;
    assign v   = i_item.wdata;
    assign idx = a[2:1];

    always_comb begin
        n_ctl       = r_ctl;
        n_ra        = r_ra;
        n_pl        = r_pl;
        n_c3s       = r_c3s;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_cnt       = r_cnt;
        rdata       = 8'h00;
        nmi_pre     = 1'b0;
        after       = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wp;
        o_mem_wdata = v;
        if (i_accept) begin
            case (tipr_pkg::t_cmd'(i_item.cmd))
                tipr_pkg::CMD_HOST_RD: begin
                    rdata = a[0] ? r_ra[idx] : r_ctl.hs[idx];
                    case (a)
                        tipr_pkg::REG_DATA1: begin
                            if (r_cnt != '0) begin
                                n_ra[0] = i_mem_q;
                                n_cnt   = r_cnt - 1'b1;
                                if (n_cnt != '0) begin
                                    n_rp = next_ptr(r_rp);
                                end else begin
                                    n_ctl.hs[0][7] = 1'b0;
                                end
                                n_ctl.ps[0][6] = 1'b1;
                            end
                        end
                        tipr_pkg::REG_DATA2, tipr_pkg::REG_DATA4: begin
                            if (r_ctl.hs[idx][7]) begin
                                n_ctl.hs[idx][7] = 1'b0;
                                n_ctl.ps[idx][6] = 1'b1;
                            end
                        end
                        tipr_pkg::REG_DATA3: begin
                            if (r_ctl.th3 != 2'd0) begin
                                n_ra[2]          = r_c3s;
                                n_ctl.th3        = r_ctl.th3 - 2'd1;
                                n_ctl.ps[2][7:6] = 2'b11;
                                if (n_ctl.th3 == 2'd0) begin
                                    n_ctl.hs[2][7] = 1'b0;
                                    if (r_ctl.hs[0][3]) begin
                                        n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                tipr_pkg::CMD_HOST_WR: begin
                    case (a)
                        tipr_pkg::REG_STAT1: begin
                            if (r_ctl.enable) begin
                                nmi_pre = tipr_pkg::nmi_cond(r_ctl);
                                if (v[7]) begin
                                    if (v[6]) begin
                                        n_ctl = tipr_pkg::CTL_RESET;
                                        n_rp  = '0;
                                        n_wp  = '0;
                                        n_cnt = '0;
                                    end else begin
                                        n_ctl.hs[0] = r_ctl.hs[0] | {2'b00, v[5:0]};
                                    end
                                end else begin
                                    n_ctl.hs[0] = r_ctl.hs[0] & ~{2'b00, v[5:0]};
                                end
                                n_ctl.flags[tipr_pkg::FLAG_RST] = n_ctl.hs[0][5];
                                after = tipr_pkg::nmi_cond(n_ctl);
                                if (!nmi_pre && after) begin
                                    n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b1;
                                end
                                if (!after) begin
                                    n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b0;
                                end
                                n_ctl.flags[tipr_pkg::FLAG_IRQ] =
                                    (n_ctl.hs[0][1] && n_ctl.ps[0][7]) ||
                                    (n_ctl.hs[0][2] && n_ctl.ps[3][7]);
                            end
                        end
                        tipr_pkg::REG_DATA1: begin
                            n_pl[0]        = v;
                            n_ctl.ps[0][7] = 1'b1;
                            n_ctl.hs[0][6] = 1'b0;
                            if (r_ctl.hs[0][1]) begin
                                n_ctl.flags[tipr_pkg::FLAG_IRQ] = 1'b1;
                            end
                        end
                        tipr_pkg::REG_DATA2: begin
                            n_pl[1]        = v;
                            n_ctl.ps[1][7] = 1'b1;
                            n_ctl.hs[1][6] = 1'b0;
                        end
                        tipr_pkg::REG_DATA3: begin
                            if (r_ctl.hs[0][4]) begin
                                if (r_ctl.tp3 < 2'd2) begin
                                    if (r_ctl.tp3 == 2'd0) begin
                                        n_pl[2] = v;
                                    end else begin
                                        n_pl[3] = v;
                                    end
                                    n_ctl.tp3 = r_ctl.tp3 + 2'd1;
                                end
                                if (n_ctl.tp3 == 2'd2) begin
                                    n_ctl.ps[2][7] = 1'b1;
                                    n_ctl.hs[2][6] = 1'b0;
                                    if (r_ctl.hs[0][3]) begin
                                        n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b1;
                                    end
                                end
                            end else begin
                                n_pl[2]        = v;
                                n_ctl.tp3      = 2'd1;
                                n_ctl.ps[2][7] = 1'b1;
                                n_ctl.hs[2][6] = 1'b0;
                                if (r_ctl.hs[0][3]) begin
                                    n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b1;
                                end
                            end
                        end
                        tipr_pkg::REG_DATA4: begin
                            n_pl[4]        = v;
                            n_ctl.ps[3][7] = 1'b1;
                            n_ctl.hs[3][6] = 1'b0;
                            if (r_ctl.hs[0][2]) begin
                                n_ctl.flags[tipr_pkg::FLAG_IRQ] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                tipr_pkg::CMD_PAR_RD: begin
                    case (a)
                        tipr_pkg::REG_STAT1: begin
                            rdata = r_ctl.ps[0] | {2'b00, r_ctl.hs[0][5:0]};
                        end
                        tipr_pkg::REG_DATA1: begin
                            rdata = r_pl[0];
                            if (r_ctl.ps[0][7]) begin
                                n_ctl.ps[0][7] = 1'b0;
                                n_ctl.hs[0][6] = 1'b1;
                                if (!r_ctl.ps[3][7]) begin
                                    n_ctl.flags[tipr_pkg::FLAG_IRQ] = 1'b0;
                                end
                            end
                        end
                        tipr_pkg::REG_DATA2: begin
                            rdata = r_pl[1];
                            if (r_ctl.ps[1][7]) begin
                                n_ctl.ps[1][7] = 1'b0;
                                n_ctl.hs[1][6] = 1'b1;
                            end
                        end
                        tipr_pkg::REG_DATA3: begin
                            rdata = r_pl[2];
                            if (r_ctl.tp3 != 2'd0) begin
                                n_pl[2]   = r_pl[3];
                                n_ctl.tp3 = r_ctl.tp3 - 2'd1;
                                if (n_ctl.tp3 == 2'd0) begin
                                    n_ctl.hs[2][6] = 1'b1;
                                    n_ctl.ps[2][7] = 1'b0;
                                end
                                if ((r_ctl.th3 != 2'd0) &&
                                    (r_ctl.hs[0][4] || (n_ctl.tp3 == 2'd0))) begin
                                    n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b0;
                                end
                            end
                        end
                        tipr_pkg::REG_DATA4: begin
                            rdata = r_pl[4];
                            if (r_ctl.ps[3][7]) begin
                                n_ctl.ps[3][7] = 1'b0;
                                n_ctl.hs[3][6] = 1'b1;
                                if (!r_ctl.ps[0][7]) begin
                                    n_ctl.flags[tipr_pkg::FLAG_IRQ] = 1'b0;
                                end
                            end
                        end
                        default: begin
                            rdata = r_ctl.ps[idx];
                        end
                    endcase
                end
                tipr_pkg::CMD_PAR_WR: begin
                    case (a)
                        tipr_pkg::REG_DATA1: begin
                            if (r_cnt < CW'(DEPTH)) begin
                                if (r_cnt == '0) begin
                                    n_ra[0] = v;
                                end else begin
                                    o_mem_we = 1'b1;
                                    n_wp     = next_ptr(r_wp);
                                end
                                n_cnt          = r_cnt + 1'b1;
                                n_ctl.hs[0][7] = 1'b1;
                                if (n_cnt == CW'(DEPTH)) begin
                                    n_ctl.ps[0][6] = 1'b0;
                                end
                            end
                        end
                        tipr_pkg::REG_DATA2, tipr_pkg::REG_DATA4: begin
                            n_ra[idx]        = v;
                            n_ctl.hs[idx][7] = 1'b1;
                            n_ctl.ps[idx][6] = 1'b0;
                        end
                        tipr_pkg::REG_DATA3: begin
                            if (r_ctl.hs[0][4]) begin
                                if (r_ctl.th3 < 2'd2) begin
                                    if (r_ctl.th3 == 2'd0) begin
                                        n_ra[2] = v;
                                    end else begin
                                        n_c3s = v;
                                    end
                                    n_ctl.th3 = r_ctl.th3 + 2'd1;
                                end
                                if (n_ctl.th3 == 2'd2) begin
                                    n_ctl.hs[2][7] = 1'b1;
                                    n_ctl.ps[2][6] = 1'b0;
                                end
                                if (!(r_ctl.tp3 > 2'd1)) begin
                                    n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b0;
                                end
                            end else begin
                                n_ra[2]          = v;
                                n_ctl.th3        = 2'd1;
                                n_ctl.hs[2][7]   = 1'b1;
                                n_ctl.ps[2][7:6] = 2'b00;
                                if (r_ctl.tp3 == 2'd0) begin
                                    n_ctl.flags[tipr_pkg::FLAG_NMI] = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                tipr_pkg::CMD_RESET: begin
                    n_ctl = tipr_pkg::CTL_RESET;
                    n_rp  = '0;
                    n_wp  = '0;
                    n_cnt = '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cfg_we) begin
            n_ctl.enable = i_cfg_enable;
        end
    end

    assign o_mem_raddr = i_rst_n ? n_rp : '0;
    assign o_enable    = r_ctl.enable;

    assign o_result.rdata = rdata;
    assign o_result.irq   = n_ctl.flags[tipr_pkg::FLAG_IRQ];
    assign o_result.nmi   = n_ctl.flags[tipr_pkg::FLAG_NMI];
    assign o_result.rst   = n_ctl.flags[tipr_pkg::FLAG_RST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= tipr_pkg::CTL_RESET;
            r_ra  <= '0;
            r_pl  <= '0;
            r_c3s <= 8'h00;
            r_rp  <= '0;
            r_wp  <= '0;
            r_cnt <= '0;
        end else begin
            r_ctl <= n_ctl;
            r_ra  <= n_ra;
            r_pl  <= n_pl;
            r_c3s <= n_c3s;
            r_rp  <= n_rp;
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/tube_interprocessor_register_block.sv
// Each access does a single read-modify-write of the state and queues its result.
// Throughput: one access per cycle while the result queue is not full.
// The channel 1 store is read ahead at the next read pointer, with write forwarding.
// A two-entry result queue keeps the input ready while one result waits to be taken.
// Reset is synchronous and active low; all state is ready on the first cycle after it.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tube_interprocessor_register_block
// Four-channel host/parasite register block with a byte FIFO on channel 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tube_interprocessor_register_block #(
    parameter int FIFO_DEPTH = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [2:0] reg_addr, [10:3] wdata, [15:11] zero
    input  logic [15:0]                  s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] rdata, [8] irq_out, [9] nmi_out, [10] reset_out, [15:11] zero
    output logic [15:0]                  m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tipr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int PW = $clog2(FIFO_DEPTH);

    tipr_pkg::t_item   w_item;
    tipr_pkg::t_result w_result;
    tipr_pkg::t_result w_out;
    logic              w_accept;
    logic              w_cfg_we;
    logic              w_enable;
    logic              w_mem_we;
    logic [PW-1:0]     w_mem_waddr;
    logic [7:0]        w_mem_wdata;
    logic [PW-1:0]     w_mem_raddr;
    logic [7:0]        w_mem_q;

    assign w_item.cmd      = s_axis_tuser;
    assign w_item.reg_addr = s_axis_tdata[2:0];
    assign w_item.wdata    = s_axis_tdata[10:3];
    assign w_accept        = s_axis_tvalid && s_axis_tready;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == tipr_pkg::REG_ENABLE_IDX);
    assign prdata   = (paddr[2] == tipr_pkg::REG_ENABLE_IDX) ? {31'b0, w_enable} : 32'b0;

    tipr_core #(
        .DEPTH (FIFO_DEPTH),
        .PW    (PW)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_item       (w_item),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_enable (pwdata[0]),
        .o_enable     (w_enable),
        .o_result     (w_result),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_q      (w_mem_q)
    );

    tipr_fifo_mem #(
        .DEPTH (FIFO_DEPTH),
        .AW    (PW)
    ) u_fifo_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_q     (w_mem_q)
    );

    tipr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {5'b00000, w_out.rst, w_out.nmi, w_out.irq, w_out.rdata};

    `ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted transfer left no result")
    `ASSERT_IMPL(a_empty_is_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with no result pending")
    `ASSERT_IMPL(a_mem_waddr_range, i_clk, i_rst_n, w_mem_we, w_mem_waddr < FIFO_DEPTH, "store write address out of range")
    `ASSERT_IMPL(a_mem_raddr_range, i_clk, i_rst_n, 1'b1, w_mem_raddr < FIFO_DEPTH, "store read address out of range")

endmodule
